/* rtl/rect_table_resource_parser_top_assert.svh */
// assertion macros for the resource parser
`ifndef RECT_TABLE_RESOURCE_PARSER_TOP_ASSERT_SVH
`define RECT_TABLE_RESOURCE_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RTPR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define RTPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RTPR_ASSERT_IMPL(lbl, ante, cons, msg)
`define RTPR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/rtpr_pkg.sv */
package rtpr_pkg;

  typedef enum logic [1:0] {
    PH_REF  = 2'd0,
    PH_HEAD = 2'd1,
    PH_RECT = 2'd2,
    PH_TAIL = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_RECT   = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_REF      = 3'd1,
    ST_UNTERMINATED = 3'd2,
    ST_SHORT_HEADER = 3'd3,
    ST_SHORT_RECTS  = 3'd4
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] id;
    logic [15:0]        w0;
    logic [15:0]        w1;
    logic [15:0]        w2;
    logic [15:0]        w3;
    status_e            status;
    logic               last;
  } rec_t;

  // records produced by one accepted byte, zero to two
  typedef struct packed {
    logic [1:0] count;
    rec_t       first;
    rec_t       second;
  } push_t;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0]  CharZero = 8'h30;
  localparam logic [7:0]  CharNine = 8'h39;
  localparam logic [34:0] RadixTen = 35'd10;
  localparam logic [34:0] IdMax    = 35'h7FFFFFFF;
  localparam logic [2:0]  HeadLastPos = 3'd5;
  localparam logic [2:0]  RectLastPos = 3'd7;

endpackage

/* rtl/rtpr_core.sv */
module rtpr_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 final_byte_i,
  output rtpr_pkg::push_t      push_o
);

  rtpr_pkg::phase_e phase_q, phase_d, phase_m;
  logic [2:0]  pos_q, pos_d, pos_m;
  logic [30:0] value_q, value_d, value_m;
  logic        empty_q, empty_d, empty_m;
  logic        invalid_q, invalid_d, invalid_m;
  logic [15:0] left_q, left_d, left_m;
  logic [63:0] gather_q, gather_d;

  logic [34:0] prod;
  logic [3:0]  digit;
  logic        data_emit;
  rtpr_pkg::rec_t data_rec, end_rec;
  logic signed [31:0] id;
  rtpr_pkg::status_e status;

  assign digit = data_byte_i[3:0] - rtpr_pkg::CharZero[3:0];
  assign prod  = 35'(value_q) * rtpr_pkg::RadixTen + 35'(digit);

  // byte-level update of parser state
  always_comb begin
    phase_m   = phase_q;
    pos_m     = pos_q;
    value_m   = value_q;
    empty_m   = empty_q;
    invalid_m = invalid_q;
    left_m    = left_q;
    gather_d  = gather_q;
    data_emit = 1'b0;
    data_rec  = '0;
    unique case (phase_q) inside
      rtpr_pkg::PH_REF: begin
        if (data_byte_i == 8'd0) begin
          phase_m = rtpr_pkg::PH_HEAD;
          pos_m   = '0;
        end else begin
          empty_m = 1'b0;
          if (!invalid_q) begin
            if (data_byte_i < rtpr_pkg::CharZero || data_byte_i > rtpr_pkg::CharNine) begin
              invalid_m = 1'b1;
            end else if (prod > rtpr_pkg::IdMax) begin
              invalid_m = 1'b1;
            end else begin
              value_m = prod[30:0];
            end
          end
        end
      end
      rtpr_pkg::PH_HEAD, rtpr_pkg::PH_RECT: begin
        gather_d[{pos_q, 3'b000} +: 8] = data_byte_i;
        pos_m = pos_q + 3'd1;
        if (phase_q == rtpr_pkg::PH_HEAD && pos_q == rtpr_pkg::HeadLastPos) begin
          data_emit     = 1'b1;
          data_rec.kind = rtpr_pkg::KIND_HEADER;
          data_rec.w0   = gather_d[15:0];
          data_rec.w1   = gather_d[31:16];
          data_rec.w2   = gather_d[47:32];
          left_m        = gather_d[47:32];
          phase_m       = (gather_d[47:32] == 16'd0) ? rtpr_pkg::PH_TAIL : rtpr_pkg::PH_RECT;
          pos_m         = '0;
        end else if (phase_q == rtpr_pkg::PH_RECT && pos_q == rtpr_pkg::RectLastPos) begin
          data_emit     = 1'b1;
          data_rec.kind = rtpr_pkg::KIND_RECT;
          data_rec.w0   = gather_d[15:0];
          data_rec.w1   = gather_d[31:16];
          data_rec.w2   = gather_d[47:32];
          data_rec.w3   = gather_d[63:48];
          left_m        = left_q - 16'd1;
          if (left_q == 16'd1) begin
            phase_m = rtpr_pkg::PH_TAIL;
          end
          pos_m = '0;
        end
      end
      rtpr_pkg::PH_TAIL: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (empty_m) begin
      id = '1;
    end else if (invalid_m) begin
      id = '0;
    end else begin
      id = {1'b0, value_m};
    end

    if (phase_m == rtpr_pkg::PH_REF) begin
      status = rtpr_pkg::ST_UNTERMINATED;
    end else if (invalid_m) begin
      status = rtpr_pkg::ST_BAD_REF;
    end else if (phase_m == rtpr_pkg::PH_HEAD) begin
      status = rtpr_pkg::ST_SHORT_HEADER;
    end else if (phase_m == rtpr_pkg::PH_RECT && left_m != 16'd0) begin
      status = rtpr_pkg::ST_SHORT_RECTS;
    end else begin
      status = rtpr_pkg::ST_OK;
    end
  end

  always_comb begin
    end_rec        = '0;
    end_rec.kind   = rtpr_pkg::KIND_END;
    end_rec.id     = id;
    end_rec.status = status;
    end_rec.last   = 1'b1;

    push_o        = '0;
    push_o.second = end_rec;
    if (data_emit) begin
      push_o.first      = data_rec;
      push_o.first.id   = id;
      push_o.first.last = !final_byte_i;
    end else begin
      push_o.first = end_rec;
    end
    if (accept_i) begin
      push_o.count = 2'(data_emit) + 2'(final_byte_i);
    end

    // the final byte puts the parser back to its start state
    if (final_byte_i) begin
      phase_d   = rtpr_pkg::PH_REF;
      pos_d     = '0;
      value_d   = '0;
      empty_d   = 1'b1;
      invalid_d = 1'b0;
      left_d    = '0;
    end else begin
      phase_d   = phase_m;
      pos_d     = pos_m;
      value_d   = value_m;
      empty_d   = empty_m;
      invalid_d = invalid_m;
      left_d    = left_m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rtpr_pkg::PH_REF;
      pos_q     <= '0;
      value_q   <= '0;
      empty_q   <= 1'b1;
      invalid_q <= 1'b0;
      left_q    <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      value_q   <= value_d;
      empty_q   <= empty_d;
      invalid_q <= invalid_d;
      left_q    <= left_d;
    end
  end

  // gathered bytes are always written before they are read
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      gather_q <= gather_d;
    end
  end

endmodule

/* rtl/rtpr_out_queue.sv */
module rtpr_out_queue #(
  parameter int unsigned Depth = rtpr_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rtpr_pkg::push_t push_i,
  input  logic            stall_i,
  output logic            valid_o,
  output logic            full_o,
  output rtpr_pkg::rec_t  rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rtpr_pkg::rec_t entries_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign valid_o = (count_q != '0);
  // room for two records is kept so one byte never overruns
  assign full_o  = (count_q > CntW'(Depth - 2));
  assign rec_o   = entries_q[rd_q];
  assign pop     = valid_o && !stall_i;
  assign wr_nx   = ptr_inc(wr_q);

  always_comb begin
    rd_d    = pop ? ptr_inc(rd_q) : rd_q;
    count_d = count_q + CntW'(push_i.count) - CntW'(pop);
    case (push_i.count)
      2'd1:    wr_d = wr_nx;
      2'd2:    wr_d = ptr_inc(wr_nx);
      default: wr_d = wr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entries_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      entries_q[wr_nx] <= push_i.second;
    end
  end

endmodule

/* rtl/rect_table_resource_parser_top.sv */
// a byte's records are written into a small output queue when the byte is taken
// throughput: one byte per cycle; a byte may cause two records, which leave one per cycle
// while out_stall_i is low, and input stalls only while the queue lacks room for two
// reset: asynchronous active low, parser back to the reference string, queue emptied
`include "rect_table_resource_parser_top_assert.svh"

module rect_table_resource_parser_top #(
  parameter int unsigned QueueDepth = rtpr_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               final_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         record_kind_o,
  output logic signed [31:0] resource_id_o,
  output logic [15:0]        word_zero_o,
  output logic [15:0]        word_one_o,
  output logic [15:0]        word_two_o,
  output logic [15:0]        word_three_o,
  output logic [2:0]         status_o,
  output logic               last_of_run_o
);

  logic            accept;
  logic            full;
  rtpr_pkg::push_t push;
  rtpr_pkg::rec_t  rec;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  rtpr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .push_o       (push)
  );

  rtpr_out_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .full_o  (full),
    .rec_o   (rec)
  );

  assign record_kind_o = rec.kind;
  assign resource_id_o = rec.id;
  assign word_zero_o   = rec.w0;
  assign word_one_o    = rec.w1;
  assign word_two_o    = rec.w2;
  assign word_three_o  = rec.w3;
  assign status_o      = rec.status;
  assign last_of_run_o = rec.last;

  `RTPR_ASSERT_NEXT(a_final_gives_record, accept && final_byte_i, out_valid_o, "no end record queued")
  `RTPR_ASSERT_IMPL(a_stall_means_pending, in_stall_o, out_valid_o, "input stalled with empty queue")
  `RTPR_ASSERT_IMPL(a_end_is_last, out_valid_o && record_kind_o == rtpr_pkg::KIND_END, last_of_run_o, "end record not last")
  `RTPR_ASSERT_IMPL(a_status_only_end, out_valid_o && record_kind_o != rtpr_pkg::KIND_END, status_o == rtpr_pkg::ST_OK, "status on data record")

endmodule

/* dv/rect_table_resource_parser_top_test.sv */
`timescale 1ns / 100ps

module rect_table_resource_parser_top_test;

  localparam int unsigned RefIdLimit   = 32'h7FFF_FFFF;
  localparam int unsigned HeaderBytes  = 6;
  localparam int unsigned RectBytes    = 8;
  localparam int unsigned IdlePercent  = 21;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomBytes  = 750;
  localparam int unsigned SteadyBytes  = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         data_byte_i = 8'h00;
  logic               final_byte_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         record_kind_o;
  logic signed [31:0] resource_id_o;
  logic [15:0]        word_zero_o;
  logic [15:0]        word_one_o;
  logic [15:0]        word_two_o;
  logic [15:0]        word_three_o;
  logic [2:0]         status_o;
  logic               last_of_run_o;

  rect_table_resource_parser_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .final_byte_i  (final_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .record_kind_o (record_kind_o),
    .resource_id_o (resource_id_o),
    .word_zero_o   (word_zero_o),
    .word_one_o    (word_one_o),
    .word_two_o    (word_two_o),
    .word_three_o  (word_three_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

  // parser state as the predictor sees it
  rtpr_pkg::phase_e parse_phase = rtpr_pkg::PH_REF;
  logic [2:0]  parse_pos = '0;
  logic [30:0] parse_value = '0;
  bit          parse_empty = 1'b1;
  bit          parse_invalid = 1'b0;
  logic [15:0] parse_rects_left = '0;
  logic [63:0] parse_gather = '0;

  rtpr_pkg::rec_t expected_records[$];
  logic [7:0]  res_q[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  bit          idle_on = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_byte(input logic [7:0] b);
    res_q.insert(res_q.size(), b);
  endfunction

  function automatic void add_record(input rtpr_pkg::rec_t r);
    expected_records.insert(expected_records.size(), r);
  endfunction

  function automatic void reset_parse_state();
    parse_phase      = rtpr_pkg::PH_REF;
    parse_pos        = '0;
    parse_value      = '0;
    parse_empty      = 1'b1;
    parse_invalid    = 1'b0;
    parse_rects_left = '0;
    parse_gather     = '0;
  endfunction

  function automatic rtpr_pkg::rec_t make_record(input rtpr_pkg::kind_e kind,
                                                 input logic [15:0] w0,
                                                 input logic [15:0] w1,
                                                 input logic [15:0] w2,
                                                 input logic [15:0] w3,
                                                 input rtpr_pkg::status_e st);
    rtpr_pkg::rec_t r;
    r.kind   = kind;
    r.id     = parse_empty ? -32'sd1 : (parse_invalid ? 32'sd0 : {1'b0, parse_value});
    r.w0     = w0;
    r.w1     = w1;
    r.w2     = w2;
    r.w3     = w3;
    r.status = st;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic void predict_records(input logic [7:0] b, input logic fin);
    int unsigned digit;
    int unsigned next_pos;
    int unsigned pushed;
    rtpr_pkg::status_e st;
    pushed = 0;
    if (parse_phase == rtpr_pkg::PH_REF) begin
      if (b == 8'h00) begin
        parse_phase  = rtpr_pkg::PH_HEAD;
        parse_pos    = '0;
        parse_gather = '0;
      end else begin
        parse_empty = 1'b0;
        if (!parse_invalid) begin
          if (b < rtpr_pkg::CharZero || b > rtpr_pkg::CharNine) begin
            parse_invalid = 1'b1;
          end else begin
            digit = b - rtpr_pkg::CharZero;
            // next digit would carry past the signed 32-bit maximum
            if (32'(parse_value) > (RefIdLimit - digit) / 10) begin
              parse_invalid = 1'b1;
            end else begin
              parse_value = 31'(32'(parse_value) * 10 + digit);
            end
          end
        end
      end
    end else if (parse_phase == rtpr_pkg::PH_HEAD || parse_phase == rtpr_pkg::PH_RECT) begin
      parse_gather = parse_gather | ({56'd0, b} << (8 * parse_pos));
      next_pos = parse_pos + 1;
      parse_pos = 3'(next_pos);
      if (parse_phase == rtpr_pkg::PH_HEAD && next_pos >= HeaderBytes) begin
        add_record(make_record(rtpr_pkg::KIND_HEADER, parse_gather[15:0],
                               parse_gather[31:16], parse_gather[47:32],
                               16'h0000, rtpr_pkg::ST_OK));
        pushed++;
        parse_rects_left = parse_gather[47:32];
        parse_phase = (parse_rects_left == 16'd0) ? rtpr_pkg::PH_TAIL : rtpr_pkg::PH_RECT;
        parse_pos = '0;
        parse_gather = '0;
      end else if (parse_phase == rtpr_pkg::PH_RECT && next_pos >= RectBytes) begin
        add_record(make_record(rtpr_pkg::KIND_RECT, parse_gather[15:0],
                               parse_gather[31:16], parse_gather[47:32],
                               parse_gather[63:48], rtpr_pkg::ST_OK));
        pushed++;
        parse_rects_left = parse_rects_left - 16'd1;
        if (parse_rects_left == 16'd0) begin
          parse_phase = rtpr_pkg::PH_TAIL;
        end
        parse_pos = '0;
        parse_gather = '0;
      end
    end
    if (fin) begin
      if (parse_phase == rtpr_pkg::PH_REF) begin
        st = rtpr_pkg::ST_UNTERMINATED;
      end else if (parse_invalid) begin
        st = rtpr_pkg::ST_BAD_REF;
      end else if (parse_phase == rtpr_pkg::PH_HEAD) begin
        st = rtpr_pkg::ST_SHORT_HEADER;
      end else if (parse_phase == rtpr_pkg::PH_RECT && parse_rects_left != 16'd0) begin
        st = rtpr_pkg::ST_SHORT_RECTS;
      end else begin
        st = rtpr_pkg::ST_OK;
      end
      add_record(make_record(rtpr_pkg::KIND_END, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, st));
      pushed++;
      reset_parse_state();
    end
    if (pushed > 0) begin
      expected_records[expected_records.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // compare every record transfer against the oldest prediction
  always @(posedge clk_i) begin
    rtpr_pkg::rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_records.size() == 0) begin
        $error("record transfer with no record expected");
        mismatch_count++;
      end else begin
        want = expected_records.pop_front();
        check_field("record_kind", want.kind, record_kind_o);
        check_field("resource_id", want.id, resource_id_o);
        check_field("word_zero", want.w0, word_zero_o);
        check_field("word_one", want.w1, word_one_o);
        check_field("word_two", want.w2, word_two_o);
        check_field("word_three", want.w3, word_three_o);
        check_field("status", want.status, status_o);
        check_field("last_of_run", want.last, last_of_run_o);
      end
    end
  end

  // receiver side: long hold when asked, random stalls while idle_on is set, no stalls otherwise
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else if (idle_on) begin
      out_stall_i <= ($urandom_range(99) < IdlePercent);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // valid stays high between back-to-back transfers, lowered only in a gap
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (idle_on && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_records(b, fin);
    bytes_sent++;
  endtask

  task automatic send_resource();
    foreach (res_q[i]) begin
      send_byte(res_q[i], i == res_q.size() - 1);
    end
  endtask

  task automatic wait_records_out();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (expected_records.size() != 0);
  endtask

  function automatic void push_decimal(input longint unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(rtpr_pkg::CharZero + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) begin
      add_byte(digits[i]);
    end
  endfunction

  function automatic void push_word(input logic [15:0] w);
    add_byte(w[7:0]);
    add_byte(w[15:8]);
  endfunction

  function automatic void push_rand(input int unsigned n);
    repeat (n) add_byte(8'($urandom));
  endfunction

  function automatic logic [7:0] rand_non_digit();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255, 1));
    end while (b >= rtpr_pkg::CharZero && b <= rtpr_pkg::CharNine);
    return b;
  endfunction

  task automatic build_random_resource();
    int unsigned pick;
    int unsigned n_rects;
    int unsigned keep;
    logic [15:0] count;
    res_q.delete();
    pick = $urandom_range(19);
    if (pick == 1) begin
      push_decimal(64'd2147483648 + $urandom_range(5000));
    end else if (pick == 2) begin
      push_decimal({$urandom, $urandom});
    end else if (pick == 3) begin
      push_decimal($urandom_range(999));
      add_byte(rand_non_digit());
      push_decimal($urandom_range(99));
    end else if (pick == 4) begin
      push_decimal(64'd2147483647 - $urandom_range(3));
    end else if (pick == 5) begin
      add_byte(rtpr_pkg::CharZero);
      push_decimal($urandom_range(99));
    end else if (pick < 13) begin
      push_decimal($urandom_range(9999));
    end else if (pick > 13) begin
      push_decimal($urandom & RefIdLimit);
    end
    // unterminated reference now and then
    if ($urandom_range(19) == 0) begin
      if ($urandom_range(1)) begin
        add_byte(rand_non_digit());
      end
      if (res_q.size() == 0) begin
        add_byte(rand_non_digit());
      end
      return;
    end
    add_byte(8'h00);
    pick = $urandom_range(19);
    if (pick == 0) begin
      count = 16'h0000;
    end else if (pick == 1) begin
      count = 16'hFFFF;
    end else if (pick == 2) begin
      count = 16'($urandom);
    end else begin
      count = 16'($urandom_range(4));
    end
    n_rects = (count <= 4) ? count : $urandom_range(2);
    push_word(16'($urandom));
    push_word(16'($urandom));
    push_word(count);
    push_rand(n_rects * RectBytes);
    push_rand($urandom_range(3));
    // cut the resource short at a random byte
    if ($urandom_range(7) == 0) begin
      keep = $urandom_range(res_q.size(), 1);
      while (res_q.size() > keep) begin
        void'(res_q.pop_back());
      end
    end
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    // empty reference, ends on its terminator
    res_q.delete();
    add_byte(8'h00);
    send_resource();
    // single non-digit, never terminated
    res_q.delete();
    add_byte("A");
    send_resource();
    // largest identifier, zero rectangles, ends on the last header byte
    res_q.delete();
    push_decimal(64'd2147483647);
    add_byte(8'h00);
    push_word(16'hFFFF);
    push_word(16'hFFFF);
    push_word(16'h0000);
    send_resource();
    // one past the largest identifier
    res_q.delete();
    push_decimal(64'd2147483648);
    add_byte(8'h00);
    send_resource();
    // non-digit in the reference, rectangle and end record from one byte
    res_q.delete();
    push_decimal(12);
    add_byte("a");
    add_byte(8'h00);
    push_word(16'h0000);
    push_word(16'h0000);
    push_word(16'h0001);
    repeat (8) add_byte(8'hFF);
    send_resource();
    // empty reference, rectangle array short by one
    res_q.delete();
    add_byte(8'h00);
    push_word(16'h8001);
    push_word(16'h7FFE);
    push_word(16'h0002);
    repeat (8) add_byte(8'h00);
    send_resource();
    // leading zeros, trailing bytes ignored
    res_q.delete();
    add_byte(rtpr_pkg::CharZero);
    push_decimal(0);
    add_byte(8'h00);
    push_word(16'h0001);
    push_word(16'h0002);
    push_word(16'h0001);
    push_rand(10);
    send_resource();
    // huge count cut short
    res_q.delete();
    push_decimal(7);
    add_byte(8'h00);
    push_word(16'h0003);
    push_word(16'h0004);
    push_word(16'hFFFF);
    push_rand(8);
    send_resource();
    // header cut short
    res_q.delete();
    push_decimal(9);
    add_byte(8'h00);
    push_rand(3);
    send_resource();
    // digits with no terminator
    res_q.delete();
    push_decimal(42);
    send_resource();
    wait_records_out();
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_cycles = 150;
    repeat (3) begin
      res_q.delete();
      push_decimal($urandom_range(999));
      add_byte(8'h00);
      push_word(16'($urandom));
      push_word(16'($urandom));
      push_word(16'h0004);
      push_rand(4 * RectBytes);
      send_resource();
    end
    wait_records_out();
  endtask

  task automatic test_steady_stream();
    int unsigned stop_at;
    idle_on = 1'b0;
    stop_at = bytes_sent + SteadyBytes;
    while (bytes_sent < stop_at) begin
      build_random_resource();
      send_resource();
    end
    wait_records_out();
  endtask

  task automatic test_random_stream();
    int unsigned stop_at;
    idle_on = 1'b1;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) begin
      build_random_resource();
      send_resource();
    end
    wait_records_out();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_steady_stream();
    test_random_stream();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_records.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* rect_table_resource_parser_top.f */
+incdir+rtl
rtl/rtpr_pkg.sv
rtl/rtpr_core.sv
rtl/rtpr_out_queue.sv
rtl/rect_table_resource_parser_top.sv
dv/rect_table_resource_parser_top_test.sv
